// ----- src/frq_pkg.sv -----
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and codes for the ready queue with removal by identifier.
// ----------------------------------------------------------------------------
package frq_pkg;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_YIELD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TERM  = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } frq_state_t;

  // per-cell controls, one of them at most is set in a cycle
  typedef struct packed {
    logic shift;  // take the entry of the neighbor toward the tail
    logic load;   // take the new identifier
  } cell_ctl_t;

endpackage

// ----- src/frq_cell.sv -----
// ----------------------------------------------------------------------------
// frq_cell
// One slot of the queue: holds an identifier, compares it, shifts or loads.
// ----------------------------------------------------------------------------
module frq_cell #(
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  frq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [ID_BITS-1:0] right_id,
  input  logic [ID_BITS-1:0] cmp_id,
  output logic [ID_BITS-1:0] id,
  output logic               hit
);
  import frq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      id <= right_id;
    end else if (ctl.load) begin
      id <= new_id;
    end
  end

  // only slots below the count take part in a search
  assign hit = occupied && (id == cmp_id);

endmodule

// ----- src/fifo_ready_queue_with_removal_core.sv -----
// ----------------------------------------------------------------------------
// fifo_ready_queue_with_removal_core
// FIFO ready queue of thread identifiers with add, yield and terminate by id.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (lowest bit up)                   | tuser/tlast
//  --------+-----+------------------------------------------------+------------
//  s_*     | in  | mode[1:0], thread_id[ID_BITS-1:0], zero pad    | none
//  m_*     | out | status[1:0], dispatched_id, queue_count, pad   | none
//
//  - an item is accepted, then executed in the execute state, in which every
//    cell compares in parallel and the row shifts by one slot toward the head or the tail slot loads
//  - the execute cycle waits while the result register still holds an
//    unaccepted item, so a stalled output holds the queue untouched
//  - s_tready is high only between items; the next item may be offered while
//    a result waits on m_*
//  - rst clears the count, the sequencer and the output valid; slot contents
//    are not cleared, slots at or above the count are never looked at
//
module fifo_ready_queue_with_removal_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_BITS    = ((frq_pkg::MODE_W + ID_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ((frq_pkg::STATUS_W + ID_BITS + CNT_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  // slave side
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,   // mode, thread_id, zero pad
  // master side
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata    // status, dispatched_id, queue_count, pad
);
  import frq_pkg::*;

  // sequencer and command hold registers
  frq_state_t           state, state_next;
  logic [MODE_W-1:0]    cmd_mode;
  logic [ID_BITS-1:0]   cmd_id;

  // occupancy
  logic [CNT_BITS-1:0]  count, count_next;

  // result register
  logic [STATUS_W-1:0]  o_status, status_next;
  logic [ID_BITS-1:0]   o_disp, disp_next;
  logic [CNT_BITS-1:0]  o_count;

  // cell row
  cell_ctl_t            ctl [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   cell_id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ, hit, rm_mask;
  logic                 found, full, empty, exec_go, in_go;
  logic                 do_shift, do_load;

  assign in_go    = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  // execute only when the result register can take the outcome
  assign exec_go  = (state == S_EXEC) && (!m_tvalid || m_tready);

  assign full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // first match from the head: every slot at or beyond it moves one toward
  // the head; hit | -hit sets all bits from the lowest set bit upward
  assign found   = |hit;
  assign rm_mask = hit | (~hit + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1});

  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = ST_DONE;
    disp_next   = '0;
    do_shift    = 1'b0;
    do_load     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_go) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_mode)
          MODE_ADD: begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              do_load    = 1'b1;
              count_next = count + 1'b1;
            end
          end
          MODE_YIELD: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else begin
              disp_next  = cell_id[0];
              do_shift   = 1'b1;
              count_next = count - 1'b1;
            end
          end
          MODE_TERM: begin
            if (!found) begin
              status_next = ST_NOT_FOUND;
            end else begin
              do_shift   = 1'b1;
              count_next = count - 1'b1;
            end
          end
          default: begin
            // unused code: no change, plain done
          end
        endcase
        if (exec_go) begin
          state_next = S_IDLE;
        end else begin
          count_next = count;
          do_shift   = 1'b0;
          do_load    = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // row of cells, slot 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] right;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_id[i+1];
    end

    assign occ[i]       = (CNT_BITS'(i) < count);
    // yield moves the whole row, terminate only from the match onward
    assign ctl[i].shift = do_shift && ((cmd_mode == MODE_YIELD) || rm_mask[i]);
    assign ctl[i].load  = do_load && (count == CNT_BITS'(i));

    frq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .occupied (occ[i]),
      .new_id   (cmd_id),
      .right_id (right),
      .cmp_id   (cmd_id),
      .id       (cell_id[i]),
      .hit      (hit[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      cmd_mode <= s_tdata[MODE_W-1:0];
      cmd_id   <= s_tdata[MODE_W +: ID_BITS];
    end
    if (exec_go) begin
      o_status <= status_next;
      o_disp   <= disp_next;
      o_count  <= count_next;
    end
  end

  assign m_tdata = OUT_BITS'({o_count, o_disp, o_status});

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(count))
    else $error("count moved with no item in work");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + 1'b1)
      || (count == $past(count) - 1'b1))
    else $error("count moved by more than one");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> (m_tvalid && (o_count == count)))
    else $error("reported count differs from queue count");

  a_single_ctl: assert property (@(posedge clk) disable iff (rst)
    !(do_shift && do_load))
    else $error("shift and load in the same cycle");

endmodule
